@@ hw/rtl/dfa_sa_pkg.sv @@
// Shared types and constants for the table-driven DFA string acceptor.
`timescale 1ns / 1ps
package dfa_sa_pkg;

  localparam int STATE_COUNT  = 64;
  localparam int SYMBOL_COUNT = 256;

  // Field widths of the channel payload
  localparam int OP_W    = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;

  // Index widths into the edge table and the accepting marks
  localparam int ST_CLOG = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int SY_CLOG = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ST_IW   = (ST_CLOG < STATE_W) ? ST_CLOG : STATE_W;
  localparam int SYM_IW  = (SY_CLOG < SYM_W) ? SY_CLOG : SYM_W;
  localparam int ADDR_W  = ST_IW + SYM_IW;
  localparam int TBL_DEPTH = 1 << ADDR_W;
  localparam int MARK_N    = 1 << ST_IW;
  localparam int ENTRY_W   = STATE_W + 1;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_MARK = 2'd1,
    OP_FEED = 2'd2,
    OP_END  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_LOOKUP
  } back_st_t;

  // Classified command: ok says the fields are in range for the op
  typedef struct packed {
    op_t                op;
    logic               ok;
    logic [ST_IW-1:0]   src;
    logic [STATE_W-1:0] dst;
    logic [SYM_IW-1:0]  sym;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ hw/rtl/dfa_sa_if.sv @@
// Valid/ready channel interfaces for the input items and the results.
`timescale 1ns / 1ps
interface dfa_sa_in_if;
  import dfa_sa_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [STATE_W-1:0] source_state;
  logic [STATE_W-1:0] target_state;
  logic [SYM_W-1:0]   symbol;

  modport source (output valid, output op, output source_state, output target_state,
                  output symbol, input ready);
  modport sink   (input valid, input op, input source_state, input target_state,
                  input symbol, output ready);
endinterface

interface dfa_sa_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic hit_missing_edge;

  modport source (output valid, output accepted, output hit_missing_edge, input ready);
  modport sink   (input valid, input accepted, input hit_missing_edge, output ready);
endinterface

@@ hw/rtl/dfa_sa_front.sv @@
// Front end: accepts input items, range-checks them and pushes commands.
`timescale 1ns / 1ps
module dfa_sa_front (
  dfa_sa_in_if.sink              in_ch,
  input  dfa_sa_pkg::q_stat_t    q_stat,
  input  dfa_sa_pkg::back_stat_t bk_stat,
  output logic                   push,
  output dfa_sa_pkg::cmd_t       cmd
);
  import dfa_sa_pkg::*;

  logic src_in, dst_in, sym_in;

  // Hold off while the queue is full or the table is being swept
  assign in_ch.ready = !q_stat.full && !bk_stat.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign src_in = 32'(in_ch.source_state) < STATE_COUNT;
  assign dst_in = 32'(in_ch.target_state) < STATE_COUNT;
  assign sym_in = 32'(in_ch.symbol) < SYMBOL_COUNT;

  always_comb begin
    cmd.op  = op_t'(in_ch.op);
    cmd.src = in_ch.source_state[ST_IW-1:0];
    cmd.dst = in_ch.target_state;
    cmd.sym = in_ch.symbol[SYM_IW-1:0];
    unique case (op_t'(in_ch.op))
      OP_SET:  cmd.ok = src_in && dst_in && sym_in;
      OP_MARK: cmd.ok = src_in;
      OP_FEED: cmd.ok = sym_in;
      OP_END:  cmd.ok = 1'b1;
      default: cmd.ok = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/dfa_sa_queue.sv @@
// Short command queue decoupling the front end from the table engine.
`timescale 1ns / 1ps
module dfa_sa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dfa_sa_pkg::cmd_t    cmd_in,
  input  logic                pop,
  output dfa_sa_pkg::cmd_t    cmd_out,
  output dfa_sa_pkg::q_stat_t q_stat
);
  import dfa_sa_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign cmd_out      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    priority case ({push, pop})
      2'b10:   cnt_nxt = Q_CNT_W'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = Q_CNT_W'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ hw/rtl/dfa_sa_back.sv @@
// Table engine: edge memory, accepting marks, current state and result register.
`timescale 1ns / 1ps
module dfa_sa_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dfa_sa_pkg::q_stat_t    q_stat,
  input  dfa_sa_pkg::cmd_t       cmd_in,
  output logic                   pop,
  output dfa_sa_pkg::back_stat_t bk_stat,
  dfa_sa_out_if.source           out_ch
);
  import dfa_sa_pkg::*;

  // Edge table entry: valid bit above the target state
  logic [ENTRY_W-1:0] tbl [TBL_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  back_st_t           st_r, st_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               dead_r, dead_nxt;
  logic [MARK_N-1:0]  marks_r;
  logic               out_valid_r, out_valid_nxt;
  logic               acc_r, acc_nxt;
  logic               miss_r, miss_nxt;

  logic               wr_en, rd_en, mark_set;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               cur_marked;

  assign bk_stat.clearing    = st_r == BK_CLEAR;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = acc_r;
  assign out_ch.hit_missing_edge = miss_r;

  assign cur_marked = (32'(cur_r) < STATE_COUNT) && marks_r[cur_r[ST_IW-1:0]];

  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    acc_nxt       = acc_r;
    miss_nxt      = miss_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = {cmd_in.src, cmd_in.sym};
    wr_data       = {1'b1, cmd_in.dst};
    rd_en         = 1'b0;
    rd_addr       = {cur_r[ST_IW-1:0], cmd_in.sym};
    mark_set      = 1'b0;
    unique case (st_r)
      BK_CLEAR: begin
        // Sweep the table once, one entry a cycle
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = ADDR_W'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == {ADDR_W{1'b1}}) begin
          st_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!q_stat.empty) begin
          unique case (cmd_in.op)
            OP_SET: begin
              pop   = 1'b1;
              wr_en = cmd_in.ok;
            end
            OP_MARK: begin
              pop      = 1'b1;
              mark_set = cmd_in.ok;
            end
            OP_FEED: begin
              pop = 1'b1;
              if (!dead_r) begin
                if (!cmd_in.ok) begin
                  dead_nxt = 1'b1;
                end else begin
                  rd_en  = 1'b1;
                  st_nxt = BK_LOOKUP;
                end
              end
            end
            OP_END: begin
              // Wait until the result register is free
              if (!out_valid_nxt) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                acc_nxt       = !dead_r && cur_marked;
                miss_nxt      = dead_r;
                cur_nxt       = '0;
                dead_nxt      = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_LOOKUP: begin
        if (rd_data_r[STATE_W]) begin
          cur_nxt = rd_data_r[STATE_W-1:0];
        end else begin
          dead_nxt = 1'b1;
        end
        st_nxt = BK_RUN;
      end
      default: st_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      out_valid_r <= 1'b0;
      marks_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
      if (mark_set) begin
        marks_r[cmd_in.src] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    miss_r <= miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl[rd_addr];
    end
  end

  a_lookup_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_LOOKUP) |-> ($past(st_r) == BK_RUN && $past(rd_en)))
    else $error("lookup state entered without a table read");

  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_LOOKUP) |=> (st_r == BK_RUN))
    else $error("lookup state held for more than one cycle");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_CLEAR) |-> (!out_valid_r && !pop))
    else $error("activity during the table clearing pass");

  a_dead_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (dead_r && pop && cmd_in.op == OP_FEED) |=> ($stable(cur_r) && dead_r))
    else $error("symbol after a missing edge changed the state");

endmodule

@@ hw/rtl/dfa_string_acceptor.sv @@
// Top level of the table-driven DFA string acceptor.
// Result path: an accepted end item passes the queue and then the result register.
// Engine: set, mark and end items use only the run state, an end item waiting for a free result
//   register; a live feed item also takes the lookup state, as its table read is registered.
// Reset: synchronous; afterwards the edge table's 16384 entries are swept, one entry a cycle,
//   with in_ch.ready low; marks, current state and dead flag clear at once.
`timescale 1ns / 1ps
module dfa_string_acceptor (
  input  logic          clk,
  input  logic          rst_n,
  dfa_sa_in_if.sink     in_ch,
  dfa_sa_out_if.source  out_ch
);
  import dfa_sa_pkg::*;

  logic       push, pop;
  cmd_t       cmd_push, cmd_head;
  q_stat_t    q_stat;
  back_stat_t bk_stat;

  dfa_sa_front u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .push    (push),
    .cmd     (cmd_push)
  );

  dfa_sa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_push),
    .pop     (pop),
    .cmd_out (cmd_head),
    .q_stat  (q_stat)
  );

  dfa_sa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .cmd_in  (cmd_head),
    .pop     (pop),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

endmodule
